[rtl/char_lcd_nibble_sequencer_core_defines.svh]
// assertion macros used by the checker file
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_DEFINES_SVH

// property checked on every clock edge outside reset
`define CLNS_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that must also hold across reset
`define CLNS_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/clns_pkg.sv]
`default_nettype none

package clns_pkg;

   // depth of the queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;

   localparam logic KIND_INIT = 1'b1;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] WRITE_LAST_STEP = 4'd1;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 4'd15;

   localparam logic [14:0] WAIT_POWER_ON  = 15'd30000;
   localparam logic [14:0] WAIT_FIRST_SET = 15'd4100;
   localparam logic [14:0] WAIT_CLEAR     = 15'd3000;
   localparam logic [14:0] WAIT_SHORT     = 15'd100;

   localparam logic [7:0] CMD_FUNC_2LINE = 8'h28;
   localparam logic [7:0] CMD_DISP_OFF   = 8'h08;
   localparam logic [7:0] CMD_CLEAR      = 8'h01;
   localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
   localparam logic [7:0] CMD_DISP_ON    = 8'h0F;

   localparam logic [3:0] NIBBLE_FUNC_SET = 4'h3;
   localparam logic [3:0] NIBBLE_4BIT     = 4'h2;

   typedef struct packed {
      logic       kind;
      logic [7:0] byte_value;
      logic       register_select;
   } req_type;

   typedef struct packed {
      logic        strobe_res;
      logic        rs_level;
      logic [3:0]  pin_nibble;
      logic [14:0] wait_after;
      logic        last;
   } rsp_type;

   // classified item as it travels from front to back
   typedef struct packed {
      logic              is_init;
      logic              register_select;
      logic [7:0]        byte_value;
      logic [STEP_W-1:0] last_step;
   } op_type;

   // port wiring mirrors d4..d7
   function automatic logic [3:0] rev4(input logic [3:0] n);
      return {n[0], n[1], n[2], n[3]};
   endfunction

   // one pin action of an item at a given step
   function automatic rsp_type action_at(input op_type op, input logic [STEP_W-1:0] step);
      rsp_type     a;
      logic [3:0]  nib;
      logic        strobe;
      logic [14:0] wt;
      strobe = 1'b1;
      wt     = WAIT_SHORT;
      nib    = 4'h0;
      if (op.is_init) begin
         unique case (step)
            4'd0: begin
               strobe = 1'b0;
               wt     = WAIT_POWER_ON;
            end
            4'd1: begin
               nib = NIBBLE_FUNC_SET;
               wt  = WAIT_FIRST_SET;
            end
            4'd2, 4'd3: nib = NIBBLE_FUNC_SET;
            4'd4:  nib = NIBBLE_4BIT;
            4'd5:  nib = CMD_FUNC_2LINE[7:4];
            4'd6:  nib = CMD_FUNC_2LINE[3:0];
            4'd7:  nib = CMD_DISP_OFF[7:4];
            4'd8:  nib = CMD_DISP_OFF[3:0];
            4'd9:  nib = CMD_CLEAR[7:4];
            4'd10: nib = CMD_CLEAR[3:0];
            4'd11: begin
               strobe = 1'b0;
               wt     = WAIT_CLEAR;
            end
            4'd12: nib = CMD_ENTRY_MODE[7:4];
            4'd13: nib = CMD_ENTRY_MODE[3:0];
            4'd14: nib = CMD_DISP_ON[7:4];
            4'd15: nib = CMD_DISP_ON[3:0];
         endcase
      end else begin
         nib = step[0] ? op.byte_value[3:0] : op.byte_value[7:4];
      end
      a.strobe_res = strobe;
      a.rs_level   = op.is_init ? 1'b0 : op.register_select;
      a.pin_nibble = strobe ? rev4(nib) : 4'h0;
      a.wait_after = wt;
      a.last       = (step == op.last_step);
      return a;
   endfunction

endpackage

`default_nettype wire

[rtl/clns_front.sv]
`default_nettype none

module clns_front
   import clns_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   output logic         op_valid,
   output op_type       op_data,
   input  wire logic    queue_full
);

   logic   valid_ff, valid_in;
   op_type op_ff, op_in;
   logic   accept, handoff;

   assign handoff   = valid_ff && !queue_full;
   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;

   // classify: init runs sixteen actions, a write two
   always_comb begin
      op_in.is_init         = (req_item.kind == KIND_INIT);
      op_in.register_select = req_item.register_select;
      op_in.byte_value      = req_item.byte_value;
      op_in.last_step       = op_in.is_init ? INIT_LAST_STEP : WRITE_LAST_STEP;
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (handoff) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_in;
      end
   end

   assign op_valid = valid_ff;
   assign op_data  = op_ff;

endmodule

`default_nettype wire

[rtl/clns_queue.sv]
`default_nettype none

module clns_queue
   import clns_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  wire op_type push_op,
   output logic        full,
   input  wire logic   pop,
   output op_type      head_op,
   output logic        not_empty
);

   localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CNT_W = $clog2(Depth + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Depth - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Depth);

   op_type           slot_ff [Depth];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_fire, pop_fire;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign push_fire = push && !full;
   assign pop_fire  = pop && not_empty;
   assign head_op   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_fire, pop_fire})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

[rtl/clns_back.sv]
`default_nettype none

module clns_back
   import clns_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   op_valid,
   input  wire op_type op_data,
   output logic        op_pop,
   output logic        rsp_valid,
   input  wire logic   rsp_stall,
   output rsp_type     rsp_item
);

   logic              busy_ff, busy_in;
   op_type            op_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;
   rsp_type           act;
   logic              advance, emit, finishing;

   assign act       = action_at(op_ff, step_ff);
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign emit      = busy_ff && advance;
   assign finishing = emit && act.last;
   // next item is loaded in the cycle the current one gives its last action
   assign op_pop    = op_valid && (!busy_ff || finishing);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      priority if (op_pop) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (finishing) begin
         busy_in = 1'b0;
      end else if (emit) begin
         step_in = step_ff + 1'b1;
      end
      rsp_valid_in = advance ? emit : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         op_ff <= op_data;
      end
      if (emit) begin
         rsp_ff <= act;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

[rtl/char_lcd_nibble_sequencer_core.sv]
// Character LCD nibble sequencer for a 4-bit bus. Each accepted item becomes
// a run of pin actions: a write item gives two enable strobes (high nibble,
// then low nibble, each nibble bit-reversed for the port wiring, each
// followed by a 100 us wait); an init item gives the sixteen-action power-on
// run. One action leaves per cycle while rsp_stall is low and the back part
// holds an item; that rate is set by the single action register of the back
// part, which steps one action per cycle. The first action passes through
// the front register, the queue, the item register and the action register
// of the back part. The front part keeps taking items while the back part is
// busy, up to QueueDepth items plus one held in the front.
`default_nettype none

module char_lcd_nibble_sequencer_core
   import clns_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_item,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_item
);

   // front to queue
   logic   front_valid;
   op_type front_op;
   logic   queue_full;

   // queue to back
   logic   queue_not_empty;
   op_type queue_head;
   logic   queue_pop;

   // front: accept and classify each item
   clns_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .op_valid   (front_valid),
      .op_data    (front_op),
      .queue_full (queue_full)
   );

   // short queue so front and back stall on their own
   clns_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_op   (front_op),
      .full      (queue_full),
      .pop       (queue_pop),
      .head_op   (queue_head),
      .not_empty (queue_not_empty)
   );

   // back: step through the actions of one item, one per cycle while rsp_stall is low
   clns_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (queue_not_empty),
      .op_data   (queue_head),
      .op_pop    (queue_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

[rtl/clns_checker.sv]
`default_nettype none

`include "char_lcd_nibble_sequencer_core_defines.svh"

module clns_checker
   import clns_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_item
);

   logic wait_only, strobe_ok_wait, idle_ok_wait;
   logic quiet, rsp_held, wait_pins_ok, strobe_out;

   assign wait_only      = rsp_valid && !rsp_item.strobe_res;
   assign strobe_ok_wait = (rsp_item.wait_after == WAIT_SHORT) ||
                           (rsp_item.wait_after == WAIT_FIRST_SET);
   assign idle_ok_wait   = (rsp_item.wait_after == WAIT_POWER_ON) ||
                           (rsp_item.wait_after == WAIT_CLEAR);
   assign quiet          = !rsp_valid && !req_stall;
   assign rsp_held       = rsp_valid && rsp_stall;
   assign wait_pins_ok   = (rsp_item.rs_level == 1'b0) && (rsp_item.pin_nibble == 4'h0) &&
                           idle_ok_wait;
   assign strobe_out     = rsp_valid && rsp_item.strobe_res;

   // nothing leaves and nothing is held off right after reset
   `CLNS_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, reset |=> quiet, "busy after reset")

   // a stalled item holds
   `CLNS_ASSERT(a_rsp_hold, clock, reset, rsp_held |=> rsp_valid && $stable(rsp_item), "rsp moved")

   // wait-only actions drive quiet pins and a long wait
   `CLNS_ASSERT(a_wait_only_pins, clock, reset, wait_only |-> wait_pins_ok, "bad wait-only action")

   // strobes only carry the short or first-set wait
   `CLNS_ASSERT(a_strobe_wait, clock, reset, strobe_out |-> strobe_ok_wait, "bad strobe wait")

endmodule

bind char_lcd_nibble_sequencer_core clns_checker u_clns_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

[bench/tb_char_lcd_nibble_sequencer_core.sv]
module tb_char_lcd_nibble_sequencer_core;

   // item kinds: init comes from the package, a plain byte write is the other value
   localparam logic KIND_WRITE = ~clns_pkg::KIND_INIT;

   // lcd timing in microseconds, as the controller data sheet asks
   localparam logic [14:0] POWER_ON_US  = 15'd30000;
   localparam logic [14:0] FIRST_SET_US = 15'd4100;
   localparam logic [14:0] CLEAR_US     = 15'd3000;
   localparam logic [14:0] STROBE_US    = 15'd100;

   // commands of the power-on run
   localparam logic [7:0] FUNC_SET_2LINE = 8'h28;
   localparam logic [7:0] DISPLAY_OFF    = 8'h08;
   localparam logic [7:0] CLEAR_DISPLAY  = 8'h01;
   localparam logic [7:0] ENTRY_INC      = 8'h06;
   localparam logic [7:0] DISPLAY_ON     = 8'h0F;

   // bare nibbles of the wake-up strobes
   localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
   localparam logic [3:0] BUS_4BIT_NIBBLE = 4'h2;

   localparam int MAX_GAP       = 19;
   localparam int RANDOM_ITEMS  = 200;
   localparam int CHUNK_ITEMS   = 40;
   localparam int QUIET_ROWS    = 9;
   localparam int DRAIN_CYCLES  = 24;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int PRINT_ERRORS  = 40;

   // one row of the directed table; typed rows carry the first and final action
   typedef struct packed {
      clns_pkg::req_type item;
      logic              typed;
      clns_pkg::rsp_type first_act;
      clns_pkg::rsp_type final_act;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   clns_pkg::req_type req_item;
   logic              rsp_valid;
   logic              rsp_stall;
   clns_pkg::rsp_type rsp_item;

   // pin actions still owed by the block, oldest first
   clns_pkg::rsp_type expected_actions[$];
   // scratch list built for one item
   clns_pkg::rsp_type lcd_actions[$];
   stim_row_type      directed_rows[$];

   int mismatch_count;
   int actions_checked;
   int init_sent;
   int write_sent;
   int directed_sent;

   // idling on or off per side, changed between stretches of items
   bit sender_idles;
   bit receiver_idles;

   char_lcd_nibble_sequencer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   // port bits are wired d7..d4, so the nibble is mirrored
   function automatic logic [3:0] mirror4(input logic [3:0] n);
      logic [3:0] m;
      for (int i = 0; i < 4; i++) m[3-i] = n[i];
      return m;
   endfunction

   // one action as seen on the port (nibble already in port order)
   function automatic clns_pkg::rsp_type make_action(input logic strobe, input logic rs,
                                                     input logic [3:0] port_nib,
                                                     input logic [14:0] wt,
                                                     input logic fin);
      clns_pkg::rsp_type a;
      a.strobe_res = strobe;
      a.rs_level   = rs;
      a.pin_nibble = port_nib;
      a.wait_after = wt;
      a.last       = fin;
      return a;
   endfunction

   function automatic void push_strobe(input logic rs, input logic [3:0] nib,
                                       input logic [14:0] wt);
      lcd_actions.push_back(make_action(1'b1, rs, mirror4(nib), wt, 1'b0));
   endfunction

   // wait-only action drives rs and data low
   function automatic void push_pause(input logic [14:0] wt);
      lcd_actions.push_back(make_action(1'b0, 1'b0, 4'h0, wt, 1'b0));
   endfunction

   // a byte goes out high nibble first
   function automatic void push_byte(input logic [7:0] b, input logic rs);
      push_strobe(rs, b[7:4], STROBE_US);
      push_strobe(rs, b[3:0], STROBE_US);
   endfunction

   // pin actions for one accepted item, left in lcd_actions
   function automatic void predict_actions(input clns_pkg::req_type it);
      clns_pkg::rsp_type tail;
      lcd_actions.delete();
      if (it.kind == clns_pkg::KIND_INIT) begin
         // byte and rs of the item play no part here
         push_pause(POWER_ON_US);
         push_strobe(1'b0, WAKE_NIBBLE, FIRST_SET_US);
         push_strobe(1'b0, WAKE_NIBBLE, STROBE_US);
         push_strobe(1'b0, WAKE_NIBBLE, STROBE_US);
         push_strobe(1'b0, BUS_4BIT_NIBBLE, STROBE_US);
         push_byte(FUNC_SET_2LINE, 1'b0);
         push_byte(DISPLAY_OFF, 1'b0);
         push_byte(CLEAR_DISPLAY, 1'b0);
         push_pause(CLEAR_US);
         push_byte(ENTRY_INC, 1'b0);
         push_byte(DISPLAY_ON, 1'b0);
      end else begin
         push_byte(it.byte_value, it.register_select);
      end
      // flag the closing action of the item
      tail      = lcd_actions.pop_back();
      tail.last = 1'b1;
      lcd_actions.push_back(tail);
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_ERRORS) $display("ERROR at %0t: %s", $time, msg);
   endtask

   task automatic compare_field(input string field, input logic [14:0] got,
                                input logic [14:0] want);
      if (got !== want)
         report_error($sformatf("action %0d %s: got %0d, expected %0d",
                                actions_checked, field, got, want));
   endtask

   task automatic check_action(input clns_pkg::rsp_type got);
      clns_pkg::rsp_type want;
      if (expected_actions.size() == 0) begin
         report_error($sformatf("pin action %h with nothing owed", got));
         return;
      end
      want = expected_actions.pop_front();
      actions_checked++;
      compare_field("strobe_res", 15'(got.strobe_res), 15'(want.strobe_res));
      compare_field("rs_level",   15'(got.rs_level),   15'(want.rs_level));
      compare_field("pin_nibble", 15'(got.pin_nibble), 15'(want.pin_nibble));
      compare_field("wait_after", got.wait_after,      want.wait_after);
      compare_field("last",       15'(got.last),       15'(want.last));
   endtask

   // ---------------------------------------------------------------- idling

   // cycles to hold off before the next item; zero while a side is quiet
   function automatic int draw_gap(input bit idles);
      if (!idles) return 0;
      // keep plenty of back-to-back items even while idling
      return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // ---------------------------------------------------------------- request side

   // offer one item, wait for the handshake, then book its actions
   task automatic send_item(input clns_pkg::req_type it, input logic typed,
                            input clns_pkg::rsp_type first_act,
                            input clns_pkg::rsp_type final_act);
      int gap;
      gap = draw_gap(sender_idles);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_item  <= it;
      // accepted at the first rising edge with stall low
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_actions(it);
      if (typed) begin
         // hand-typed values stand in for the predictor at both ends
         lcd_actions[0]                      = first_act;
         lcd_actions[lcd_actions.size() - 1] = final_act;
      end
      foreach (lcd_actions[i]) expected_actions.push_back(lcd_actions[i]);
      if (it.kind == clns_pkg::KIND_INIT) init_sent++;
      else write_sent++;
   endtask

   function automatic void add_row(input logic kind, input logic [7:0] b, input logic rs,
                                   input logic typed, input clns_pkg::rsp_type f,
                                   input clns_pkg::rsp_type l);
      stim_row_type row;
      row.item.kind            = kind;
      row.item.byte_value      = b;
      row.item.register_select = rs;
      row.typed                = typed;
      row.first_act            = f;
      row.final_act            = l;
      directed_rows.push_back(row);
   endfunction

   // ---------------------------------------------------------------- result side

   initial begin : result_sink
      int hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = draw_gap(receiver_idles);
         if (hold > 0) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
            repeat (hold - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         // stall is low from here, so valid alone marks the handshake
         @(posedge clock);
         while (rsp_valid !== 1'b1) @(posedge clock);
         check_action(rsp_item);
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      clns_pkg::req_type it;
      stim_row_type      row;
      clns_pkg::rsp_type init_first;
      clns_pkg::rsp_type init_final;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_item        = '0;
      sender_idles    = 1'b0;
      receiver_idles  = 1'b0;
      mismatch_count  = 0;
      actions_checked = 0;
      init_sent       = 0;
      write_sent      = 0;
      directed_sent   = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // power-on run opens with the long wait and ends on the low nibble of display on
      init_first = make_action(1'b0, 1'b0, 4'h0, POWER_ON_US, 1'b0);
      init_final = make_action(1'b1, 1'b0, 4'hF, STROBE_US, 1'b1);

      // init straight after reset
      add_row(clns_pkg::KIND_INIT, 8'h00, 1'b0, 1'b1, init_first, init_final);
      // byte extremes and single set bits, port nibbles typed mirrored
      add_row(KIND_WRITE, 8'h00, 1'b0, 1'b1,
              make_action(1'b1, 1'b0, 4'h0, STROBE_US, 1'b0),
              make_action(1'b1, 1'b0, 4'h0, STROBE_US, 1'b1));
      add_row(KIND_WRITE, 8'hFF, 1'b1, 1'b1,
              make_action(1'b1, 1'b1, 4'hF, STROBE_US, 1'b0),
              make_action(1'b1, 1'b1, 4'hF, STROBE_US, 1'b1));
      add_row(KIND_WRITE, 8'hF0, 1'b0, 1'b1,
              make_action(1'b1, 1'b0, 4'hF, STROBE_US, 1'b0),
              make_action(1'b1, 1'b0, 4'h0, STROBE_US, 1'b1));
      add_row(KIND_WRITE, 8'h0F, 1'b1, 1'b1,
              make_action(1'b1, 1'b1, 4'h0, STROBE_US, 1'b0),
              make_action(1'b1, 1'b1, 4'hF, STROBE_US, 1'b1));
      add_row(KIND_WRITE, 8'h80, 1'b0, 1'b1,
              make_action(1'b1, 1'b0, 4'h1, STROBE_US, 1'b0),
              make_action(1'b1, 1'b0, 4'h0, STROBE_US, 1'b1));
      add_row(KIND_WRITE, 8'h01, 1'b1, 1'b1,
              make_action(1'b1, 1'b1, 4'h0, STROBE_US, 1'b0),
              make_action(1'b1, 1'b1, 4'h8, STROBE_US, 1'b1));
      add_row(KIND_WRITE, 8'h10, 1'b0, 1'b1,
              make_action(1'b1, 1'b0, 4'h8, STROBE_US, 1'b0),
              make_action(1'b1, 1'b0, 4'h0, STROBE_US, 1'b1));
      add_row(KIND_WRITE, 8'h08, 1'b1, 1'b1,
              make_action(1'b1, 1'b1, 4'h0, STROBE_US, 1'b0),
              make_action(1'b1, 1'b1, 4'h1, STROBE_US, 1'b1));
      // init with byte and rs set, both to be ignored
      add_row(clns_pkg::KIND_INIT, 8'hFF, 1'b1, 1'b1, init_first, init_final);
      // mixed patterns and back-to-back init runs through the predictor
      add_row(KIND_WRITE, 8'h5A, 1'b0, 1'b0, '0, '0);
      add_row(KIND_WRITE, 8'hA5, 1'b1, 1'b0, '0, '0);
      add_row(KIND_WRITE, 8'h3C, 1'b0, 1'b0, '0, '0);
      add_row(clns_pkg::KIND_INIT, 8'h7E, 1'b1, 1'b0, '0, '0);
      add_row(clns_pkg::KIND_INIT, 8'h81, 1'b0, 1'b0, '0, '0);
      add_row(KIND_WRITE, 8'hC3, 1'b0, 1'b0, '0, '0);
      add_row(KIND_WRITE, 8'h69, 1'b1, 1'b0, '0, '0);
      add_row(clns_pkg::KIND_INIT, 8'h00, 1'b0, 1'b0, '0, '0);
      add_row(KIND_WRITE, 8'h96, 1'b0, 1'b0, '0, '0);

      // first rows back to back on both sides to fill the queue, then idling
      for (int i = 0; i < directed_rows.size(); i++) begin
         sender_idles   = (i >= QUIET_ROWS);
         receiver_idles = (i >= QUIET_ROWS);
         row = directed_rows[i];
         send_item(row.item, row.typed, row.first_act, row.final_act);
         directed_sent++;
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // new idling policy per stretch: all idling, none, then mixed
         if (n % CHUNK_ITEMS == 0) begin
            if (n / CHUNK_ITEMS == 0) begin
               sender_idles   = 1'b1;
               receiver_idles = 1'b1;
            end else if (n / CHUNK_ITEMS == 1) begin
               sender_idles   = 1'b0;
               receiver_idles = 1'b0;
            end else begin
               sender_idles   = 1'($urandom_range(0, 1));
               receiver_idles = 1'($urandom_range(0, 1));
            end
         end
         // mostly byte writes, an init run now and then
         it.kind            = ($urandom_range(0, 6) == 0) ? clns_pkg::KIND_INIT : KIND_WRITE;
         it.byte_value      = 8'($urandom_range(0, 255));
         it.register_select = 1'($urandom_range(0, 1));
         send_item(it, 1'b0, '0, '0);
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then give stray actions a chance to show up
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d items (%0d directed): %0d init runs, %0d byte writes",
               init_sent + write_sent, directed_sent, init_sent, write_sent);
      $display("checked %0d pin actions under mixed stalls, %0d errors",
               actions_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("char_lcd_nibble_sequencer_core: match");
      end else begin
         $display("char_lcd_nibble_sequencer_core: mismatch");
      end
      $finish;
   end

   // ---------------------------------------------------------------- watchdog

   initial begin : watchdog
      #(LIMIT_CYCLES * 8);
      $display("timeout with %0d pin actions still owed", expected_actions.size());
      $display("char_lcd_nibble_sequencer_core: mismatch");
      $finish;
   end

endmodule
